// File: design/rrss_pkg.sv
package rrss_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_DISPATCH = 2'd0,
        OP_TICK     = 2'd1,
        OP_SLEEP    = 2'd2
    } op_t;

    // Slot state codes
    localparam logic [1:0] ST_READY   = 2'd0;
    localparam logic [1:0] ST_RUNNING = 2'd1;
    localparam logic [1:0] ST_WAITING = 2'd2;

    localparam logic signed [16:0] TICK_STEP = 17'sd2;
    localparam logic [15:0]        RUN_MAX   = 16'hFFFF;

    // One entry of the slot table; all-zero is the reset entry
    typedef struct packed {
        logic [1:0]         st;
        logic signed [16:0] sleep_left;
        logic [15:0]        run_cnt;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// File: design/round_robin_sleep_scheduler.sv
// Round-robin task scheduler with sleep timers. Each input beat carries an
// operation in s_tuser (dispatch, 2 ms tick, sleep current task) and a sleep
// time in s_tdata; every accepted beat yields exactly one result beat. The
// per-slot state (ready/running/waiting, signed sleep counter, saturating run
// counter) lives in one slot memory with a single read and a single write
// port, so the block works on one beat at a time. Dispatch and sleep go
// through a read, a modify/write and an output load; a tick sweeps the
// active slots through the memory at one slot per cycle; an unused code
// skips to the output load. A new beat is taken as soon as the previous
// result sits in the output register, even if it has not been taken yet.
// task_count is to be written through cfg_we/cfg_wdata only while idle;
// the block does not enforce this. 0 acts as 1 and values above MAX_TASKS
// act as MAX_TASKS. Slots never written read as ready with zero counters
// (per-slot valid flags), so no clearing pass is needed after reset.
module round_robin_sleep_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,     // task_count

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [15:0] sleep_time
    input  logic [1:0]  s_tuser,       // [1:0] operation

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [2:0] task_index, [18:3] run_count, rest 0
    output logic [0:0]  m_tuser        // [0] dispatched
);
    import rrss_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_TICK = 4'b0100,
        S_DONE = 4'b1000
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [3:0]        task_count_reg;
    op_t               op_reg;
    logic [15:0]       stime_reg;
    logic [CNT_W-1:0]  scan_reg;         // next slot to examine, may equal count
    logic [IDX_W-1:0]  cur_reg;          // slot last examined by dispatch
    logic [IDX_W-1:0]  addr_reg;         // slot whose data is coming out of the RAM
    logic              rd_valid_reg;     // that slot had been written before
    logic [MAX_TASKS-1:0] valid_reg;

    logic              res_disp_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [15:0]       res_rc_reg;

    logic              m_valid_reg;
    logic              m_disp_reg;
    logic [2:0]        m_idx_reg;
    logic [15:0]       m_rc_reg;

    logic [CNT_W-1:0]  n_act;
    logic [IDX_W-1:0]  disp_idx;
    logic              in_beat;
    logic              out_free;
    logic              tick_last;
    op_t               in_op;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             ent_cur;
    slot_t             ent_new;
    logic              started;
    logic [IDX_W+2:0]  idx_wide;

    // effective task count, clamped to 1..MAX_TASKS
    always_comb begin
        if (task_count_reg == 4'd0) begin
            n_act = CNT_W'(1);
        end else if (32'(task_count_reg) > MAX_TASKS) begin
            n_act = CNT_W'(MAX_TASKS);
        end else begin
            n_act = CNT_W'(task_count_reg);
        end
    end

    // pointer beyond the count wraps to slot 0
    assign disp_idx  = (scan_reg >= n_act) ? '0 : scan_reg[IDX_W-1:0];

    assign in_op     = op_t'(s_tuser);
    assign s_tready  = (state_reg == S_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign tick_last = (CNT_W'(addr_reg) + CNT_W'(1)) == n_act;

    // unwritten slots read as the reset entry
    assign ent_cur   = rd_valid_reg ? slot_t'(ram_rdata) : '0;
    assign wr_en     = (state_reg == S_MOD) || (state_reg == S_TICK);

    // read request on accept of dispatch, sleep or tick, one slot ahead in a sweep
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    case (in_op)
                        OP_DISPATCH: begin
                            rd_en   = 1'b1;
                            rd_addr = disp_idx;
                        end
                        OP_SLEEP: begin
                            rd_en   = 1'b1;
                            rd_addr = cur_reg;
                        end
                        OP_TICK: begin
                            rd_en   = 1'b1;
                            rd_addr = '0;
                        end
                        default: begin
                            rd_en = 1'b0;
                        end
                    endcase
                end
            end
            S_TICK: begin
                if (!tick_last) begin
                    rd_en   = 1'b1;
                    rd_addr = addr_reg + IDX_W'(1);
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    case (in_op)
                        OP_DISPATCH: state_next = S_MOD;
                        OP_SLEEP:    state_next = S_MOD;
                        OP_TICK:     state_next = S_TICK;
                        default:     state_next = S_DONE;
                    endcase
                end
            end
            S_MOD:   state_next = S_DONE;
            S_TICK:  state_next = tick_last ? S_DONE : S_TICK;
            S_DONE:  state_next = out_free ? S_IDLE : S_DONE;
            default: state_next = S_IDLE;
        endcase
    end

    rrss_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_TASKS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (addr_reg),
        .wdata (ent_new),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    rrss_slot_update u_update (
        .op         (op_reg),
        .sleep_time (stime_reg),
        .ent_in     (ent_cur),
        .ent_out    (ent_new),
        .started    (started)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            task_count_reg <= 4'd2;
            scan_reg       <= '0;
            cur_reg        <= '0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                task_count_reg <= cfg_wdata;
            end
            if (in_beat && (in_op == OP_DISPATCH)) begin
                cur_reg  <= disp_idx;
                scan_reg <= CNT_W'(disp_idx) + CNT_W'(1);
            end
            if (wr_en) begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (in_beat) begin
            op_reg       <= in_op;
            stime_reg    <= s_tdata;
            res_disp_reg <= 1'b0;
            res_idx_reg  <= '0;
            res_rc_reg   <= '0;
        end
        if (rd_en) begin
            addr_reg     <= rd_addr;
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (state_reg == S_MOD) begin
            res_disp_reg <= started;
            res_idx_reg  <= addr_reg;
            res_rc_reg   <= ent_new.run_cnt;
        end
        if (state_reg == S_DONE && out_free) begin
            m_disp_reg <= res_disp_reg;
            m_idx_reg  <= idx_wide[2:0];
            m_rc_reg   <= res_rc_reg;
        end
    end

    assign idx_wide = {3'b000, res_idx_reg};

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_disp_reg;
    assign m_tdata  = {5'b00000, m_rc_reg, m_idx_reg};

    // one beat in flight: no second accept right after one
    a_single_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("input accepted while a beat is in flight");

    // a started task has a nonzero run count
    a_started_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[18:3] != 16'd0))
        else $error("dispatched task reports zero run count");

    // scan pointer never passes the slot table
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(scan_reg) <= MAX_TASKS)
        else $error("scan pointer beyond slot table");

    // tick sweep only writes slots in use
    a_tick_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TICK) |-> (CNT_W'(addr_reg) < n_act))
        else $error("tick sweep outside active slots");

endmodule

// File: design/rrss_ram.sv
module rrss_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/rrss_slot_update.sv
module rrss_slot_update (
    input  rrss_pkg::op_t   op,
    input  logic [15:0]     sleep_time,
    input  rrss_pkg::slot_t ent_in,
    output rrss_pkg::slot_t ent_out,
    output logic            started
);
    import rrss_pkg::*;

    logic signed [16:0] sl_dec;

    assign sl_dec = ent_in.sleep_left - TICK_STEP;

    always_comb begin
        ent_out = ent_in;
        started = 1'b0;
        case (op)
            OP_DISPATCH: begin
                if (ent_in.st == ST_READY) begin
                    ent_out.st = ST_RUNNING;
                    started    = 1'b1;
                    if (ent_in.run_cnt != RUN_MAX) begin
                        ent_out.run_cnt = ent_in.run_cnt + 16'd1;
                    end
                end
            end
            OP_TICK: begin
                // waiting slots count down; everything else drops back to ready
                if (ent_in.st == ST_WAITING) begin
                    ent_out.sleep_left = sl_dec;
                    ent_out.st         = (sl_dec < TICK_STEP) ? ST_READY : ST_WAITING;
                end else begin
                    ent_out.st = ST_READY;
                end
            end
            OP_SLEEP: begin
                ent_out.st         = ST_WAITING;
                ent_out.sleep_left = signed'({1'b0, sleep_time});
            end
            default: begin
                ent_out = ent_in;
            end
        endcase
    end

endmodule

// File: tb/rrss_sched_checker.sv
module rrss_sched_checker #(
    parameter int MAX_TASKS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import rrss_pkg::*;

    localparam logic signed [16:0] SLEEP_DEC   = 17'sd2;
    localparam logic [15:0]        RUN_SAT     = 16'hFFFF;

    typedef struct packed {
        logic        dispatched;
        logic [2:0]  task_index;
        logic [15:0] run_count;
    } sched_result_t;

    // shadow copy of the slot table
    logic [1:0]         slot_st    [MAX_TASKS];
    logic signed [16:0] slot_sleep [MAX_TASKS];
    logic [15:0]        slot_runs  [MAX_TASKS];
    int                 scan_ptr;
    int                 cur_slot;
    logic [3:0]         task_cnt;
    sched_result_t      expected_results [$];

    function automatic int active_slots(input logic [3:0] cnt);
        if (cnt == 4'd0)
            return 1;
        if (cnt > MAX_TASKS)
            return MAX_TASKS;
        return int'(cnt);
    endfunction

    task automatic schedule_step(input logic [1:0] op, input logic [15:0] stime,
                                 output sched_result_t res);
        int n;
        int i;
        n   = active_slots(task_cnt);
        res = '0;
        case (op)
            OP_DISPATCH: begin
                i = (scan_ptr >= n) ? 0 : scan_ptr;
                if (slot_st[i] == ST_READY) begin
                    slot_st[i] = ST_RUNNING;
                    if (slot_runs[i] != RUN_SAT)
                        slot_runs[i] = slot_runs[i] + 16'd1;
                    res.dispatched = 1'b1;
                end
                cur_slot       = i;
                scan_ptr       = i + 1;
                res.task_index = i[2:0];
                res.run_count  = slot_runs[i];
            end
            OP_TICK: begin
                for (i = 0; i < n; i++) begin
                    if (slot_st[i] == ST_WAITING)
                        slot_sleep[i] = slot_sleep[i] - SLEEP_DEC;
                    if (slot_sleep[i] < SLEEP_DEC)
                        slot_st[i] = ST_READY;
                    if (slot_st[i] == ST_RUNNING)
                        slot_st[i] = ST_READY;
                end
            end
            OP_SLEEP: begin
                // acts on the last examined slot, ready or not, in range or not
                slot_st[cur_slot]    = ST_WAITING;
                slot_sleep[cur_slot] = $signed({1'b0, stime});
                res.task_index       = cur_slot[2:0];
                res.run_count        = slot_runs[cur_slot];
            end
            default: ;  // unused code: state kept, all-zero result
        endcase
    endtask

    task automatic flag_field(input string field, input int exp_v, input int act_v);
        fail_count++;
        $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
    endtask

    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            for (int k = 0; k < MAX_TASKS; k++) begin
                slot_st[k]    = ST_READY;
                slot_sleep[k] = '0;
                slot_runs[k]  = '0;
            end
            scan_ptr = 0;
            cur_slot = 0;
            task_cnt = 4'd2;
            expected_results.delete();
        end else begin
            if (cfg_we)
                task_cnt = cfg_wdata;
            if (s_tvalid && s_tready) begin
                schedule_step(s_tuser, s_tdata, want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $error("result beat with nothing expected: tdata 0x%0h tuser %0d",
                           m_tdata, m_tuser);
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser[0] !== want.dispatched)
                        flag_field("dispatched", want.dispatched, m_tuser[0]);
                    if (m_tdata[2:0] !== want.task_index)
                        flag_field("task_index", want.task_index, m_tdata[2:0]);
                    if (m_tdata[18:3] !== want.run_count)
                        flag_field("run_count", want.run_count, m_tdata[18:3]);
                end
                if (m_tdata[23:19] !== 5'd0)
                    flag_field("tdata padding", 0, m_tdata[23:19]);
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/round_robin_sleep_scheduler_tb.sv
module round_robin_sleep_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rrss_pkg::*;

    localparam int         CLK_HALF     = 5;
    localparam int         DRAIN_CYCLES = 12;   // drain wait before a task_count write
    localparam int         RAND_PHASES  = 10;
    localparam int         PHASE_BEATS  = 125;
    localparam logic [1:0] OP_NONE      = 2'd3; // unused operation code

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;       // [15:0] sleep_time
    logic [1:0]  s_tuser;       // [1:0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;       // [2:0] task_index, [18:3] run_count, rest 0
    logic [0:0]  m_tuser;       // [0] dispatched

    int fail_count;
    int pending;

    // no_idle and stall_req are shared between the beat source and the result sink
    bit no_idle = 1'b0;         // both sides run back to back while set
    int stall_req = 0;          // one-shot long hold-off for the sink
    int beats_sent = 0;
    int cfg_writes = 0;

    always #(CLK_HALF) aclk = ~aclk;

    round_robin_sleep_scheduler uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    rrss_sched_checker sched_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one beat. Called at a falling edge, returns at the falling edge
    // after the accept. tvalid stays high when the next beat follows with no
    // gap, so it is never dropped and raised in the same step.
    task automatic push_beat(input logic [1:0] op, input logic [15:0] stime);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= stime;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        beats_sent++;
    endtask

    // Register write only with the block idle: every result back, then a
    // DRAIN_CYCLES wait before cfg_we is raised.
    task automatic write_task_count(input logic [3:0] cnt);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cnt;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Op mix leans on dispatch and tick so slots cycle through all states.
    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return OP_DISPATCH;
        if (r < 75)
            return OP_TICK;
        if (r < 95)
            return OP_SLEEP;
        return OP_NONE;
    endfunction

    // Mostly short sleeps so tasks wake within a phase; some full-range
    // values so every bit of sleep_time toggles.
    function automatic logic [15:0] pick_sleep();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 16'($urandom_range(0, 12));
        if (r < 90)
            return 16'($urandom_range(0, 65535));
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    // Result sink: random hold-off per beat, or a long one on request.
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            int w;
            if (stall_req > 0) begin
                w         = stall_req;
                stall_req = 0;
            end else begin
                w = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        logic [1:0] op;
        logic [3:0] cnt;

        cfg_we    = 1'b0;
        cfg_wdata = 4'd0;
        s_tvalid  = 1'b0;
        s_tdata   = 16'd0;
        s_tuser   = OP_DISPATCH;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed: reset task_count of 2 ---
        push_beat(OP_DISPATCH, 16'h0000);  // slot 0 starts
        push_beat(OP_DISPATCH, 16'hFFFF);  // slot 1 starts, data ignored
        push_beat(OP_DISPATCH, 16'h0000);  // pointer wraps, slot 0 busy
        push_beat(OP_NONE,     16'hFFFF);  // unused code
        push_beat(OP_SLEEP,    16'hFFFF);  // longest sleep on slot 0
        push_beat(OP_TICK,     16'hFFFF);  // running slot 1 back to ready
        push_beat(OP_DISPATCH, 16'h0000);  // slot 1 again
        push_beat(OP_SLEEP,    16'h0001);  // sleep below one tick
        push_beat(OP_TICK,     16'h0000);  // wakes slot 1 through -1
        push_beat(OP_DISPATCH, 16'h0000);  // slot 0 still waiting
        push_beat(OP_SLEEP,    16'h0000);  // sleep on a waiting slot, zero time
        push_beat(OP_TICK,     16'h0000);

        // count of zero behaves as one slot
        write_task_count(4'd0);
        push_beat(OP_DISPATCH, 16'h0000);
        push_beat(OP_DISPATCH, 16'h0000);
        push_beat(OP_TICK,     16'h0000);

        // count above the table size behaves as the full table
        write_task_count(4'd15);
        repeat (5) push_beat(OP_DISPATCH, 16'h0000);   // slots 1..5

        // slot 5 now beyond the count: sleep still hits it, tick skips it,
        // and the stale pointer sends the next dispatch to slot 0
        write_task_count(4'd3);
        push_beat(OP_SLEEP,    16'h8000);
        push_beat(OP_TICK,     16'h0000);
        push_beat(OP_DISPATCH, 16'h0000);

        write_task_count(4'd8);
        push_beat(OP_DISPATCH, 16'h0000);
        push_beat(OP_TICK,     16'h0000);

        // --- random phases, each with its own task_count ---
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       cnt = 4'd1;
                1:       cnt = 4'd8;
                2:       cnt = 4'd0;
                3:       cnt = 4'd15;
                default: cnt = 4'($urandom_range(0, 15));
            endcase
            write_task_count(cnt);
            for (int k = 0; k < PHASE_BEATS; k++) begin
                // back-to-back stretches now and then
                if (k % 40 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                // long sink hold-off while the source keeps offering beats
                if (p == 1 && k == 20)
                    stall_req = 300;
                op = pick_op();
                push_beat(op, (op == OP_SLEEP) ? pick_sleep()
                                               : 16'($urandom_range(0, 65535)));
            end
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(negedge aclk);

        $display("covered %0d beats over %0d task_count writes (0, 1, 8, 15 and random)",
                 beats_sent, cfg_writes);
        $display("incl. stale pointer, sleep beyond count and a long output stall");
        if (fail_count == 0 && pending == 0)
            $display("round_robin_sleep_scheduler regression: pass");
        else
            $display("round_robin_sleep_scheduler regression: fail");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(50_000_000);
        $display("round_robin_sleep_scheduler regression: fail");
        $finish;
    end

endmodule

// File: files.f
design/rrss_pkg.sv
design/rrss_ram.sv
design/rrss_slot_update.sv
design/round_robin_sleep_scheduler.sv
tb/rrss_sched_checker.sv
tb/round_robin_sleep_scheduler_tb.sv
